>>> hdl/oamdma_pkg.sv
// Shared types, constants and defaults for the sprite-table DMA controller.
`default_nettype none
package oamdma_pkg;

	localparam int unsigned TableBytesDefault  = 160;
	localparam int unsigned DotsPerCopyDefault = 4;

	localparam logic [2:0] START_DELAY  = 3'd4;
	localparam logic [2:0] FINISH_DELAY = 3'd4;

	localparam logic [15:0] OAM_LO     = 16'hFE00;
	localparam logic [15:0] OAM_HI     = 16'hFEFF;
	localparam logic [15:0] HIGH_LO    = 16'hFF00;
	localparam logic [15:0] VIDEO_LO   = 16'h8000;
	localparam logic [15:0] VIDEO_HI   = 16'h9FFF;
	localparam logic [7:0]  VPAGE_LO   = 8'h80;
	localparam logic [7:0]  VPAGE_HI   = 8'h9F;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_ACK   = 2'd2,
		REQ_NONE  = 2'd3
	} req_kind_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  source_page;
		logic [15:0] query_addr;
	} oamdma_req_t;

	typedef struct packed {
		logic        is_busy;
		logic        copy_waiting;
		logic [7:0]  waiting_count;
		logic [15:0] read_address;
		logic [7:0]  table_offset;
		logic [7:0]  register_value;
		logic        access_blocked;
		logic        video_bus_source;
		logic        conflict_valid;
		logic [15:0] conflict_address;
	} oamdma_status_t;

	typedef struct packed {
		logic       busy_flag;
		logic       start_waiting;
		logic       restart_armed;
		logic       restart_warm;
		logic [7:0] last_written;
		logic [7:0] current_page;
		logic [7:0] next_page;
		logic [7:0] byte_index;
		logic [2:0] dot_phase;
		logic [2:0] start_delay_left;
		logic [2:0] finish_delay_left;
		logic [7:0] copies_owed;
	} oamdma_state_t;

endpackage
`default_nettype wire

>>> hdl/oamdma_stream_if.sv
// Valid/ready stream interface carrying one payload beat per handshake.
`default_nettype none
interface oamdma_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/oamdma_engine.sv
// Transfer state registers and their next-state logic for one request beat.
`default_nettype none
module oamdma_engine
	import oamdma_pkg::*;
#(
	parameter int unsigned TABLE_BYTES   = TableBytesDefault,
	parameter int unsigned DOTS_PER_COPY = DotsPerCopyDefault
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           fire,
	input  oamdma_req_t   req_beat,
	output oamdma_state_t state_nxt
);

	oamdma_state_t state_q;

	function automatic oamdma_state_t launch(input oamdma_state_t s);
		oamdma_state_t r;
		r                   = s;
		r.restart_warm      = s.busy_flag;
		r.busy_flag         = 1'b1;
		r.start_waiting     = 1'b0;
		r.restart_armed     = 1'b0;
		r.current_page      = s.next_page;
		r.byte_index        = '0;
		r.dot_phase         = '0;
		r.finish_delay_left = '0;
		r.copies_owed       = '0;
		return r;
	endfunction

	always_comb begin
		logic [3:0] ph;
		logic [8:0] sum;
		oamdma_state_t n;
		n   = state_q;
		ph  = {1'b0, state_q.dot_phase} + 4'd1;
		sum = {1'b0, state_q.byte_index} + {1'b0, state_q.copies_owed};
		case (req_kind_t'(req_beat.req_type))
			REQ_TICK: begin
				if (state_q.finish_delay_left != '0) begin
					n.finish_delay_left = state_q.finish_delay_left - 3'd1;
					if (state_q.finish_delay_left == 3'd1) begin
						n.busy_flag = 1'b0;
					end
				end else if (state_q.busy_flag) begin
					if (ph >= 4'(DOTS_PER_COPY) && sum < 9'(TABLE_BYTES)) begin
						n.dot_phase   = '0;
						n.copies_owed = state_q.copies_owed + 8'd1;
					end else if (ph > 4'(DOTS_PER_COPY)) begin
						n.dot_phase = 3'(DOTS_PER_COPY);
					end else begin
						n.dot_phase = ph[2:0];
					end
				end
				if (n.start_waiting && !n.restart_armed) begin
					if (n.start_delay_left != '0) begin
						n.start_delay_left = n.start_delay_left - 3'd1;
					end
					if (n.start_delay_left == '0) begin
						if (n.busy_flag && n.copies_owed != '0) begin
							n.restart_armed = 1'b1;
						end else begin
							n = launch(n);
						end
					end
				end
			end
			REQ_WRITE: begin
				n.last_written     = req_beat.source_page;
				n.next_page        = req_beat.source_page;
				n.start_waiting    = 1'b1;
				n.restart_armed    = 1'b0;
				n.start_delay_left = START_DELAY;
				if (!state_q.busy_flag) begin
					n.byte_index        = '0;
					n.dot_phase         = '0;
					n.finish_delay_left = '0;
					n.copies_owed       = '0;
				end
			end
			REQ_ACK: begin
				if (state_q.copies_owed != '0) begin
					n.copies_owed  = state_q.copies_owed - 8'd1;
					n.byte_index   = state_q.byte_index + 8'd1;
					n.restart_warm = 1'b0;
					if (state_q.restart_armed && n.copies_owed == '0) begin
						n = launch(n);
					end else if (n.byte_index >= 8'(TABLE_BYTES)) begin
						n.copies_owed       = '0;
						n.dot_phase         = '0;
						n.finish_delay_left = FINISH_DELAY;
					end
				end
			end
			default: begin
				n = state_q;
			end
		endcase
		state_nxt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

>>> hdl/oamdma_status.sv
// Status word built from the updated transfer state and the query address.
`default_nettype none
module oamdma_status
	import oamdma_pkg::*;
(
	input  oamdma_state_t  state,
	input  wire [15:0]     query_addr,
	output oamdma_status_t status_beat
);

	logic [15:0] rd_addr;
	logic        video_page;
	logic        video_addr;
	logic        blocked;
	logic        cvalid;

	always_comb begin
		rd_addr    = {state.current_page, 8'h00} + {8'h00, state.byte_index};
		video_page = state.current_page >= VPAGE_LO && state.current_page <= VPAGE_HI;
		video_addr = query_addr >= VIDEO_LO && query_addr <= VIDEO_HI;
		cvalid     = state.busy_flag && state.byte_index != '0;

		if (!state.busy_flag) begin
			blocked = 1'b0;
		end else if (query_addr >= OAM_LO && query_addr <= OAM_HI) begin
			blocked = state.byte_index != '0 || state.restart_warm;
		end else if (state.byte_index == '0 || query_addr >= HIGH_LO) begin
			blocked = 1'b0;
		end else begin
			blocked = video_addr == video_page;
		end

		status_beat.is_busy          = state.busy_flag;
		status_beat.copy_waiting     = state.copies_owed != '0;
		status_beat.waiting_count    = state.copies_owed;
		status_beat.read_address     = rd_addr;
		status_beat.table_offset     = state.byte_index;
		status_beat.register_value   = state.last_written;
		status_beat.access_blocked   = blocked;
		status_beat.video_bus_source = video_page;
		status_beat.conflict_valid   = cvalid;
		status_beat.conflict_address = cvalid ? rd_addr - 16'd1 : 16'h0000;
	end

endmodule
`default_nettype wire

>>> hdl/oamdma_out_buf.sv
// Output register with a skid entry so intake can take one more beat while a status beat is stalled.
`default_nettype none
module oamdma_out_buf
	import oamdma_pkg::*;
(
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  oamdma_status_t in_beat,
	output logic           out_valid,
	input  wire            out_ready,
	output oamdma_status_t out_beat
);

	logic           out_vld_q;
	logic           skid_vld_q;
	oamdma_status_t out_q;
	oamdma_status_t skid_q;
	logic           in_fire;

	assign in_ready  = !skid_vld_q;
	assign in_fire   = in_valid && !skid_vld_q;
	assign out_valid = out_vld_q;
	assign out_beat  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (in_fire) begin
				out_q <= in_beat;
			end
		end else if (in_fire) begin
			skid_q <= in_beat;
		end
	end

endmodule
`default_nettype wire

>>> hdl/oam_dma_transfer_controller_unit.sv
// Top level of the sprite-table DMA controller: engine, status logic and output buffer.
//
//  Channel  Dir  Payload          Content
//  req      in   oamdma_req_t     dot tick, register write or copy acknowledge
//  status   out  oamdma_status_t  transfer status after that request
//
// Each request beat produces one registered status beat; one beat per cycle
// while status does not stall. The state update and status decode sit between the
// engine registers and the output register, so the rate is set by that single stage.
// Reset clears all transfer state and empties the output buffer.
// When status stalls, one more request is taken into the skid entry, then req stalls.
`default_nettype none
module oam_dma_transfer_controller_unit
	import oamdma_pkg::*;
#(
	parameter int unsigned TABLE_BYTES   = TableBytesDefault,
	parameter int unsigned DOTS_PER_COPY = DotsPerCopyDefault
) (
	input wire              clk,
	input wire              arst_n,
	oamdma_stream_if.sink   req,
	oamdma_stream_if.source status
);

	oamdma_state_t  state_nxt;
	oamdma_status_t status_nxt;
	oamdma_req_t    req_beat;
	logic           req_ready;
	logic           fire;

	assign req_beat  = req.payload;
	assign req.ready = req_ready;
	assign fire      = req.valid && req_ready;

	oamdma_engine #(
		.TABLE_BYTES  (TABLE_BYTES),
		.DOTS_PER_COPY(DOTS_PER_COPY)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.req_beat (req_beat),
		.state_nxt(state_nxt)
	);

	oamdma_status u_status (
		.state      (state_nxt),
		.query_addr (req_beat.query_addr),
		.status_beat(status_nxt)
	);

	oamdma_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req_ready),
		.in_beat  (status_nxt),
		.out_valid(status.valid),
		.out_ready(status.ready),
		.out_beat (status.payload)
	);

endmodule
`default_nettype wire

>>> hdl/oamdma_checker.sv
// Port-level checks on the DMA controller, attached to the top level by bind.
`default_nettype none
module oamdma_checker
	import oamdma_pkg::*;
#(
	parameter int unsigned TABLE_BYTES = TableBytesDefault
) (
	input wire            clk,
	input wire            arst_n,
	input wire            out_valid,
	input wire            out_ready,
	input oamdma_status_t out_beat
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_beat))
		else $error("Stalled status beat changed.");

	a_conflict_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.conflict_valid |-> out_beat.is_busy)
		else $error("Conflict reported while idle.");

	a_conflict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_beat.conflict_valid |-> out_beat.conflict_address == 16'h0000)
		else $error("Conflict address not cleared.");

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_beat.copy_waiting == (out_beat.waiting_count != 8'd0))
			&& ({1'b0, out_beat.waiting_count} + {1'b0, out_beat.table_offset}
				<= 9'(TABLE_BYTES)))
		else $error("Copy credits out of range.");

endmodule

bind oam_dma_transfer_controller_unit oamdma_checker #(
	.TABLE_BYTES(TABLE_BYTES)
) u_oamdma_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(status.valid),
	.out_ready(status.ready),
	.out_beat (status.payload)
);
`default_nettype wire

>>> bench/oam_dma_transfer_controller_unit_tb.sv
// Self-checking testbench for the sprite-table DMA controller: directed and random requests.
`default_nettype none
module oam_dma_transfer_controller_unit_tb;
	import oamdma_pkg::*;

	localparam int unsigned TABLE_BYTES   = TableBytesDefault;
	localparam int unsigned DOTS_PER_COPY = DotsPerCopyDefault;

	logic clk;
	logic arst_n;

	oamdma_stream_if #(.payload_t(oamdma_req_t))    req_if ();
	oamdma_stream_if #(.payload_t(oamdma_status_t)) status_if ();

	oam_dma_transfer_controller_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.status (status_if)
	);

	oamdma_req_t    req_backlog[$];
	oamdma_status_t status_due[$];
	logic           req_taken = 1'b0;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;

	int mismatches = 0;
	int beats_checked = 0;
	int n_tick = 0;
	int n_write = 0;
	int n_ack = 0;
	int n_other = 0;
	int done_cnt = 0;
	int restart_win_cnt = 0;
	int sat_cnt = 0;

	// Predicted engine state.
	logic       busy_q = 1'b0;
	logic       start_pend = 1'b0;
	logic       rst_armed = 1'b0;
	logic       rst_warm = 1'b0;
	logic [7:0] reg_val = '0;
	logic [7:0] cur_page = '0;
	logic [7:0] nxt_page = '0;
	logic [7:0] byte_idx = '0;
	logic [2:0] dot_ph = '0;
	logic [2:0] start_left = '0;
	logic [2:0] finish_left = '0;
	logic [7:0] owed = '0;

	function automatic void launch_transfer();
		rst_warm = busy_q;
		busy_q = 1'b1;
		start_pend = 1'b0;
		rst_armed = 1'b0;
		cur_page = nxt_page;
		byte_idx = '0;
		dot_ph = '0;
		finish_left = '0;
		owed = '0;
	endfunction

	function automatic oamdma_status_t advance_dma(oamdma_req_t r);
		oamdma_status_t s;
		int ph;
		int sum;
		logic [15:0] base;
		logic [15:0] a;
		logic on_video;
		case (r.req_type)
			REQ_TICK: begin
				n_tick++;
				if (finish_left != 0) begin
					finish_left--;
					if (finish_left == 0)
						busy_q = 1'b0;
				end else if (busy_q) begin
					ph = dot_ph + 1;
					sum = byte_idx + owed;
					if (ph >= DOTS_PER_COPY && sum < TABLE_BYTES) begin
						dot_ph = '0;
						owed++;
					end else begin
						if (ph >= DOTS_PER_COPY)
							sat_cnt++;
						if (ph > DOTS_PER_COPY)
							ph = DOTS_PER_COPY;
						dot_ph = ph[2:0];
					end
				end
				if (start_pend && !rst_armed) begin
					if (start_left != 0)
						start_left--;
					if (start_left == 0) begin
						if (busy_q && owed != 0)
							rst_armed = 1'b1;
						else
							launch_transfer();
					end
				end
			end
			REQ_WRITE: begin
				n_write++;
				reg_val = r.source_page;
				nxt_page = r.source_page;
				start_pend = 1'b1;
				rst_armed = 1'b0;
				start_left = START_DELAY;
				if (!busy_q) begin
					byte_idx = '0;
					dot_ph = '0;
					finish_left = '0;
					owed = '0;
				end
			end
			REQ_ACK: begin
				n_ack++;
				if (owed != 0) begin
					owed--;
					byte_idx++;
					rst_warm = 1'b0;
					if (rst_armed && owed == 0) begin
						if (byte_idx >= TABLE_BYTES)
							restart_win_cnt++;
						launch_transfer();
					end else if (byte_idx >= TABLE_BYTES) begin
						owed = '0;
						dot_ph = '0;
						finish_left = FINISH_DELAY;
						done_cnt++;
					end
				end
			end
			default: begin
				n_other++;
			end
		endcase

		base = {cur_page, 8'h00};
		a = r.query_addr;
		on_video = (cur_page >= VPAGE_LO) && (cur_page <= VPAGE_HI);
		s.is_busy = busy_q;
		s.copy_waiting = (owed != 0);
		s.waiting_count = owed;
		s.read_address = base + byte_idx;
		s.table_offset = byte_idx;
		s.register_value = reg_val;
		if (!busy_q)
			s.access_blocked = 1'b0;
		else if (a >= OAM_LO && a <= OAM_HI)
			s.access_blocked = (byte_idx != 0) || rst_warm;
		else if (byte_idx == 0 || a >= HIGH_LO)
			s.access_blocked = 1'b0;
		else
			s.access_blocked = ((a >= VIDEO_LO && a <= VIDEO_HI) == on_video);
		s.video_bus_source = on_video;
		s.conflict_valid = busy_q && (byte_idx != 0);
		s.conflict_address = s.conflict_valid ? (base + byte_idx - 16'd1) : 16'h0000;
		return s;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH beat %0d: %s", beats_checked, msg);
		mismatches++;
	endtask

	task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	task automatic check_status(oamdma_status_t got, oamdma_status_t want);
		compare_field("is_busy", 16'(got.is_busy), 16'(want.is_busy));
		compare_field("copy_waiting", 16'(got.copy_waiting), 16'(want.copy_waiting));
		compare_field("waiting_count", 16'(got.waiting_count), 16'(want.waiting_count));
		compare_field("read_address", got.read_address, want.read_address);
		compare_field("table_offset", 16'(got.table_offset), 16'(want.table_offset));
		compare_field("register_value", 16'(got.register_value),
			16'(want.register_value));
		compare_field("access_blocked", 16'(got.access_blocked),
			16'(want.access_blocked));
		compare_field("video_bus_source", 16'(got.video_bus_source),
			16'(want.video_bus_source));
		compare_field("conflict_valid", 16'(got.conflict_valid),
			16'(want.conflict_valid));
		compare_field("conflict_address", got.conflict_address, want.conflict_address);
	endtask

	function automatic logic [15:0] pick_addr();
		logic [15:0] a;
		case ($urandom_range(4))
			0: a = 16'(OAM_LO + $urandom_range(255));
			1: a = 16'(VIDEO_LO + $urandom_range(16'h1FFF));
			2: a = 16'(HIGH_LO + $urandom_range(255));
			default: a = 16'($urandom_range(16'hFFFF));
		endcase
		return a;
	endfunction

	function automatic logic [7:0] pick_page();
		logic [7:0] p;
		if ($urandom_range(9) < 3)
			p = 8'(VPAGE_LO + $urandom_range(31));
		else
			p = 8'($urandom_range(255));
		return p;
	endfunction

	function automatic req_kind_t pick_kind();
		int sel;
		sel = $urandom_range(99);
		if (sel < 55)
			return REQ_TICK;
		else if (sel < 80)
			return REQ_ACK;
		else if (sel < 87)
			return REQ_WRITE;
		else if (sel < 93)
			return REQ_NONE;
		return REQ_TICK;
	endfunction

	task automatic queue_item(req_kind_t kind, logic [7:0] page, logic [15:0] addr);
		oamdma_req_t r;
		r.req_type = kind;
		r.source_page = page;
		r.query_addr = addr;
		req_backlog.push_back(r);
	endtask

	task automatic wait_idle();
		while (req_backlog.size() != 0 || req_if.valid || status_due.size() != 0)
			@(posedge clk);
	endtask

	// Drains the credits left over and starts a fresh transfer, acknowledging any
	// credit earned during the start delay so that the new transfer launches.
	task automatic start_clean();
		wait_idle();
		repeat (owed) queue_item(REQ_ACK, pick_page(), pick_addr());
		queue_item(REQ_WRITE, pick_page(), pick_addr());
		repeat (4) begin
			queue_item(REQ_TICK, pick_page(), pick_addr());
			queue_item(REQ_ACK, pick_page(), pick_addr());
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_if.valid || req_taken) begin
				if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_if.payload <= req_backlog.pop_front();
					req_if.valid <= 1'b1;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
			status_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : status_check
		oamdma_status_t want;
		req_taken <= req_if.valid && req_if.ready;
		if (req_if.valid && req_if.ready)
			status_due.push_back(advance_dma(req_if.payload));
		if (status_if.valid && status_if.ready) begin
			if (status_due.size() == 0) begin
				report_mismatch("status beat with no request outstanding");
			end else begin
				want = status_due.pop_front();
				check_status(status_if.payload, want);
			end
			beats_checked++;
		end
	end

	initial begin
		#1000000;
		$display("oam_dma_transfer_controller_unit_tb NOT OK");
		$finish;
	end

	initial begin
		int i;
		int n;
		int c_start;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.payload = '0;
		status_if.ready = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Sender idles lightly, receiver heavily.
		send_idle_pct = 22;
		recv_idle_pct = 75;
		queue_item(REQ_NONE, 8'hFF, 16'hFFFF);
		queue_item(REQ_ACK, 8'h00, 16'h0000);
		queue_item(REQ_TICK, 8'h55, 16'hFE00);
		queue_item(REQ_WRITE, 8'hFF, 16'h8000);
		queue_item(REQ_TICK, 8'hAA, 16'hFEFF);
		queue_item(REQ_TICK, 8'h00, 16'hFE00);
		queue_item(REQ_TICK, 8'h00, 16'h9FFF);
		queue_item(REQ_TICK, 8'h00, 16'hFF00);
		repeat (4) queue_item(REQ_TICK, 8'h00, 16'h7FFF);
		queue_item(REQ_ACK, 8'h00, 16'h7FFF);
		queue_item(REQ_ACK, 8'h00, 16'hFEFF);
		queue_item(REQ_WRITE, 8'h80, 16'hA000);
		repeat (4) queue_item(REQ_TICK, 8'h00, 16'h8000);
		queue_item(REQ_ACK, 8'h00, 16'hFDFF);
		queue_item(REQ_WRITE, 8'h9F, 16'h9FFF);
		queue_item(REQ_WRITE, 8'h7F, 16'hFFFF);
		queue_item(REQ_WRITE, 8'hA0, 16'hFE80);
		queue_item(REQ_NONE, 8'h00, 16'h0000);

		// Acknowledge slower than credits arrive until the table limit is hit, then
		// drain the table and restart during the completion delay.
		start_clean();
		for (i = 1; i <= 660; i++) begin
			queue_item(REQ_TICK, pick_page(), pick_addr());
			if (i % 8 == 0)
				queue_item(REQ_ACK, pick_page(), pick_addr());
		end
		repeat (6) queue_item(REQ_TICK, pick_page(), pick_addr());
		wait_idle();
		repeat (owed) queue_item(REQ_ACK, pick_page(), pick_addr());
		repeat (2) queue_item(REQ_TICK, pick_page(), pick_addr());
		queue_item(REQ_WRITE, pick_page(), pick_addr());
		repeat (8) queue_item(REQ_TICK, pick_page(), pick_addr());
		repeat (20) queue_item(pick_kind(), pick_page(), pick_addr());
		wait_idle();

		// Receiver idles lightly, sender heavily.
		send_idle_pct = 75;
		recv_idle_pct = 22;
		start_clean();
		repeat (40) queue_item(pick_kind(), pick_page(), pick_addr());
		wait_idle();

		// Full rate on both sides with short random transfers and restarts.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		c_start = n_tick + n_write + n_ack + n_other;
		while (n_tick + n_write + n_ack + n_other + req_backlog.size() - c_start < 60) begin
			queue_item(REQ_WRITE, pick_page(), pick_addr());
			n = $urandom_range(10, 30);
			repeat (n) queue_item(pick_kind(), pick_page(), pick_addr());
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (status_due.size() != 0)
			report_mismatch($sformatf("%0d status beats never arrived", status_due.size()));
		$display("Checked %0d status beats for %0d ticks, %0d writes, %0d acks, %0d unknown.",
			beats_checked, n_tick, n_write, n_ack, n_other);
		$display("Completed transfers %0d, restarts on the last copy %0d, capped dots %0d.",
			done_cnt, restart_win_cnt, sat_cnt);
		if (mismatches == 0)
			$display("oam_dma_transfer_controller_unit_tb OK");
		else
			$display("oam_dma_transfer_controller_unit_tb NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
